// ===== hw/rtl/lbof_pkg.sv =====
// ----------------------------------------------------------------------------
// lbof_pkg: shared types and tables for the line-break opportunity finder
// Break classes, pair-table action codes, the ASCII class table and the
// class-pair action table.
// ----------------------------------------------------------------------------
package lbof_pkg;

  // A break class code, 0 OP through 16 SP.
  typedef logic [4:0] class_t;

  // A pair-table action code.
  typedef logic [2:0] action_t;

  // Row or column index of the pair table (OP..WJ).
  typedef logic [3:0] pair_idx_t;

  // Result of one decision: flag and raw class of the byte.
  typedef struct packed {
    logic   segment_start;
    class_t byte_class;
  } lbof_result_t;

  localparam class_t CLS_OP = 5'd0;
  localparam class_t CLS_CL = 5'd1;
  localparam class_t CLS_CP = 5'd2;
  localparam class_t CLS_QU = 5'd3;
  localparam class_t CLS_EX = 5'd4;
  localparam class_t CLS_SY = 5'd5;
  localparam class_t CLS_IS = 5'd6;
  localparam class_t CLS_PR = 5'd7;
  localparam class_t CLS_PO = 5'd8;
  localparam class_t CLS_NU = 5'd9;
  localparam class_t CLS_AL = 5'd10;
  localparam class_t CLS_HY = 5'd11;
  localparam class_t CLS_BA = 5'd12;
  localparam class_t CLS_CM = 5'd13;
  localparam class_t CLS_WJ = 5'd14;
  localparam class_t CLS_MB = 5'd15;
  localparam class_t CLS_SP = 5'd16;

  localparam action_t ACT_DIRECT   = 3'd0;
  localparam action_t ACT_INDIRECT = 3'd1;
  localparam action_t ACT_NONE     = 3'd2;
  localparam action_t ACT_CM_IND   = 3'd3;
  localparam action_t ACT_CM_NONE  = 3'd4;

  localparam int unsigned ASCII_DEPTH = 128;
  localparam int unsigned PAIR_DIM    = 15;

  // Break class of each 7-bit ASCII code.
  localparam class_t ASCII_CLASS [ASCII_DEPTH] = '{
    5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
    5'd13, 5'd12, 5'd15, 5'd15, 5'd15, 5'd16, 5'd13, 5'd13,
    5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
    5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
    5'd16, 5'd4,  5'd3,  5'd10, 5'd7,  5'd8,  5'd10, 5'd3,
    5'd0,  5'd2,  5'd10, 5'd7,  5'd6,  5'd11, 5'd6,  5'd5,
    5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,
    5'd9,  5'd9,  5'd6,  5'd6,  5'd10, 5'd10, 5'd10, 5'd4,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd0,  5'd7,  5'd2,  5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
    5'd10, 5'd10, 5'd10, 5'd0,  5'd12, 5'd1,  5'd10, 5'd13
  };

  // Rows: segment class, columns: new class, both OP..WJ.
  localparam action_t PAIR_ACTION [PAIR_DIM][PAIR_DIM] = '{
    '{3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd2,3'd4,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd2,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd0,3'd0,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd0,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd1,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd1,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd0,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd0,3'd0,3'd1,3'd1,3'd3,3'd2},
    '{3'd0,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2},
    '{3'd1,3'd2,3'd2,3'd1,3'd2,3'd2,3'd2,3'd1,3'd1,3'd1,3'd1,3'd1,3'd1,3'd3,3'd2}
  };

endpackage

// ===== hw/rtl/lbof_classify.sv =====
// ----------------------------------------------------------------------------
// lbof_classify: byte to break-class lookup
// Maps one text byte onto its break class; bytes of 128 and up are alphabetic.
// ----------------------------------------------------------------------------
module lbof_classify
  import lbof_pkg::*;
(
  input  logic [7:0] text_byte,
  output class_t     byte_class
);

  // Top half of the byte range is treated as alphabetic, the rest is a lookup.
  always_comb begin
    if (text_byte[7]) begin
      byte_class = CLS_AL;
    end else begin
      byte_class = ASCII_CLASS[text_byte[6:0]];
    end
  end

endmodule

// ===== hw/rtl/lbof_segmenter.sv =====
// ----------------------------------------------------------------------------
// lbof_segmenter: segment state and break decision
// Holds the segment class, the previous class and the pending-start flag, and
// decides from the pair table whether a new segment starts at each byte.
// ----------------------------------------------------------------------------
module lbof_segmenter
  import lbof_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  class_t       raw_class,
  input  logic         new_line,
  output lbof_result_t result
);

  logic      start_pending_r;
  logic      start_pending_nxt;
  class_t    segment_class_r;
  class_t    segment_class_nxt;
  class_t    previous_class_r;
  class_t    previous_class_nxt;
  logic      first;
  class_t    open_class;
  pair_idx_t row_idx;
  pair_idx_t col_idx;
  action_t   act;
  logic      seg;

  // Pair-table lookup; an out-of-range segment class uses the word-joiner row.
  always_comb begin
    row_idx = (segment_class_r > CLS_WJ) ? CLS_WJ[3:0] : segment_class_r[3:0];
    col_idx = (raw_class > CLS_WJ) ? CLS_WJ[3:0] : raw_class[3:0];
    act     = PAIR_ACTION[row_idx][col_idx];
  end

  // Break decision and next state.
  always_comb begin
    first              = new_line || start_pending_r;
    open_class         = (raw_class == CLS_SP) ? CLS_WJ : raw_class;
    seg                = 1'b0;
    start_pending_nxt  = start_pending_r;
    segment_class_nxt  = segment_class_r;
    previous_class_nxt = previous_class_r;
    if (first) begin
      // A leading space opens the segment as a word joiner.
      seg                = 1'b1;
      segment_class_nxt  = open_class;
      previous_class_nxt = open_class;
      start_pending_nxt  = (open_class == CLS_MB);
    end else begin
      previous_class_nxt = raw_class;
      if (raw_class == CLS_MB) begin
        start_pending_nxt = 1'b1;
      end else if (raw_class != CLS_SP) begin
        seg = (act == ACT_DIRECT) ||
              ((act == ACT_INDIRECT) && (previous_class_r == CLS_SP));
        segment_class_nxt = raw_class;
      end
    end
  end

  // State moves only when the byte is handed to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pending_r  <= 1'b1;
      segment_class_r  <= CLS_OP;
      previous_class_r <= CLS_OP;
    end else if (advance) begin
      start_pending_r  <= start_pending_nxt;
      segment_class_r  <= segment_class_nxt;
      previous_class_r <= previous_class_nxt;
    end
  end

  assign result.segment_start = seg;
  assign result.byte_class    = raw_class;

endmodule

// ===== hw/rtl/line_break_opportunity_finder.sv =====
// ----------------------------------------------------------------------------
// line_break_opportunity_finder: streaming line-break segmenter
// Input register, class lookup with pair-table decision, result register.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the output side is ready
// and gives one result per byte, in order, through both of its registers.
// The rate of one byte per clock is set by the segment state update
// (segment class, previous class and pending flag), which completes in the
// single cycle in which a byte moves from the input register to the result
// register. A request is still accepted while a result waits at the output,
// as long as the input register is free or moving on.
module line_break_opportunity_finder
  import lbof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tuser,   // [0] new-line flag
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] byte_class, [7:5] zero
  output logic       out_tuser   // [0] segment_start
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_new_line_r;
  logic         out_valid_r;
  lbof_result_t out_result_r;
  logic         s1_advance;
  class_t       raw_class;
  lbof_result_t result;

  // Stage one moves on when the result register is empty or being emptied.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r     <= in_tdata;
      s1_new_line_r <= in_tuser;
    end
  end

  lbof_classify u_classify (
    .text_byte  (s1_byte_r),
    .byte_class (raw_class)
  );

  lbof_segmenter u_segmenter (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (s1_advance),
    .raw_class  (raw_class),
    .new_line   (s1_new_line_r),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_result_r.byte_class};
  assign out_tuser  = out_result_r.segment_start;

`ifndef SYNTH
  // A loaded input stage always reaches an empty result register.
  a_s1_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage did not move into empty result register");

  // An empty result register never holds back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input not ready while result register empty");

  // The raw class of a byte is never word joiner; only a leading space becomes one.
  a_no_raw_wj: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] != CLS_WJ))
    else $error("raw byte class reported as word joiner");
`endif

endmodule
